// ===== rtl/ibr_pkg.sv =====
// Package with the shared types, constants and helpers of the I2C bus recovery block.
`default_nettype none

package ibr_pkg;

    // Width of the phase timer and the saturation limit for loaded durations.
    localparam int TIMER_WIDTH = 24;
    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

    // Register file layout.
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic [23:0] SETTLE_RESET = 24'd2500000;
    localparam logic [9:0]  HALF_RESET   = 10'd10;
    localparam logic [23:0] POLL_RESET   = 24'd100000;
    localparam logic [7:0]  PLIM_RESET   = 8'd20;
    localparam logic [7:0]  PULSE_RESET  = 8'd20;

    typedef enum logic [2:0] {
        REG_SETTLE_TICKS = 3'd0,
        REG_HALF_TICKS   = 3'd1,
        REG_POLL_TICKS   = 3'd2,
        REG_POLL_LIMIT   = 3'd3,
        REG_PULSE_LIMIT  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_SETTLE    = 4'd1,
        PH_CLK_LOW   = 4'd2,
        PH_CLK_REL   = 4'd3,
        PH_STRETCH   = 4'd4,
        PH_START_LOW = 4'd5,
        PH_STOP_REL  = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SCL_STUCK   = 2'd1,
        ST_STRETCH_TMO = 2'd2,
        ST_SDA_STUCK   = 2'd3
    } t_status;

    typedef struct packed {
        logic [23:0] settle_ticks;
        logic [9:0]  half_ticks;
        logic [23:0] poll_ticks;
        logic [7:0]  poll_limit;
        logic [7:0]  pulse_limit;
    } t_cfg;

    typedef struct packed {
        logic action;
        logic sda_level;
        logic scl_level;
    } t_in_item;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       pullup_on;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

    // A phase of duration D counts down from D-1; zero acts as one, long values saturate.
    function automatic logic [TIMER_WIDTH-1:0] load_time(input logic [31:0] dur);
        logic [32:0] v;
        v = (dur == 32'd0) ? 33'd0 : ({1'b0, dur} - 33'd1);
        if (v > TIMER_MAX) begin
            v = TIMER_MAX;
        end
        return v[TIMER_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ibr_regs.sv =====
// Configuration register file with its APB-style access port.
`default_nettype none

module ibr_regs
    import ibr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [DATA_WIDTH-1:0] pwdata,
    output logic      [DATA_WIDTH-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_WIDTH-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_SETTLE_TICKS: n_cfg.settle_ticks = pwdata[23:0];
                REG_HALF_TICKS:   n_cfg.half_ticks   = pwdata[9:0];
                REG_POLL_TICKS:   n_cfg.poll_ticks   = pwdata[23:0];
                REG_POLL_LIMIT:   n_cfg.poll_limit   = pwdata[7:0];
                REG_PULSE_LIMIT:  n_cfg.pulse_limit  = pwdata[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks <= SETTLE_RESET;
            r_cfg.half_ticks   <= HALF_RESET;
            r_cfg.poll_ticks   <= POLL_RESET;
            r_cfg.poll_limit   <= PLIM_RESET;
            r_cfg.pulse_limit  <= PULSE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_SETTLE_TICKS: prdata = {8'd0, r_cfg.settle_ticks};
            REG_HALF_TICKS:   prdata = {22'd0, r_cfg.half_ticks};
            REG_POLL_TICKS:   prdata = {8'd0, r_cfg.poll_ticks};
            REG_POLL_LIMIT:   prdata = {24'd0, r_cfg.poll_limit};
            REG_PULSE_LIMIT:  prdata = {24'd0, r_cfg.pulse_limit};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/ibr_seq.sv =====
// Recovery sequencer: phase state, timer and counters, stepped once per accepted tick.
`default_nettype none

module ibr_seq
    import ibr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  t_in_item       i_item,
    input  t_cfg           i_cfg,
    output t_out_item      o_result
);

    t_phase                 r_phase,  n_phase;
    logic [TIMER_WIDTH-1:0] r_wait,   n_wait;
    logic [7:0]             r_pulses, n_pulses;
    logic [7:0]             r_polls,  n_polls;
    t_status                r_status, n_status;
    logic                   n_done;

    // Outcome of the SDA check shared by the settle, release and stretch phases.
    t_phase                 c_phase;
    logic [TIMER_WIDTH-1:0] c_wait;
    logic [7:0]             c_pulses;
    t_status                c_status;
    logic                   c_done;

    logic [TIMER_WIDTH-1:0] w_half_load;
    logic [TIMER_WIDTH-1:0] w_poll_load;
    logic [7:0]             w_polls_dec;

    assign w_half_load = load_time({22'd0, i_cfg.half_ticks});
    assign w_poll_load = load_time({8'd0, i_cfg.poll_ticks});
    assign w_polls_dec = (r_polls != 8'd0) ? (r_polls - 8'd1) : 8'd0;

    always_comb begin
        c_pulses = r_pulses;
        c_status = r_status;
        c_done   = 1'b0;
        if (!i_item.sda_level) begin
            if (r_pulses != 8'd0) begin
                c_pulses = r_pulses - 8'd1;
                c_phase  = PH_CLK_LOW;
                c_wait   = w_half_load;
            end else begin
                c_phase  = PH_IDLE;
                c_wait   = '0;
                c_status = ST_SDA_STUCK;
                c_done   = 1'b1;
            end
        end else begin
            c_phase = PH_START_LOW;
            c_wait  = w_half_load;
        end
    end

    // Next-state logic.
    always_comb begin
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_pulses = r_pulses;
        n_polls  = r_polls;
        n_status = r_status;
        n_done   = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (i_item.action) begin
                n_phase  = PH_SETTLE;
                n_wait   = load_time({8'd0, i_cfg.settle_ticks});
                n_pulses = i_cfg.pulse_limit;
                n_polls  = 8'd0;
            end
        end else if (r_wait != '0) begin
            n_wait = r_wait - TIMER_WIDTH'(1);
        end else begin
            case (r_phase)
                PH_SETTLE: begin
                    if (!i_item.scl_level) begin
                        n_phase  = PH_IDLE;
                        n_wait   = '0;
                        n_status = ST_SCL_STUCK;
                        n_done   = 1'b1;
                    end else begin
                        n_phase  = c_phase;
                        n_wait   = c_wait;
                        n_pulses = c_pulses;
                        n_status = c_status;
                        n_done   = c_done;
                    end
                end
                PH_CLK_LOW: begin
                    n_phase = PH_CLK_REL;
                    n_wait  = w_half_load;
                end
                PH_CLK_REL: begin
                    if (i_item.scl_level) begin
                        n_phase  = c_phase;
                        n_wait   = c_wait;
                        n_pulses = c_pulses;
                        n_status = c_status;
                        n_done   = c_done;
                    end else begin
                        n_polls = i_cfg.poll_limit;
                        if (i_cfg.poll_limit == 8'd0) begin
                            n_phase  = PH_IDLE;
                            n_wait   = '0;
                            n_status = ST_STRETCH_TMO;
                            n_done   = 1'b1;
                        end else begin
                            n_phase = PH_STRETCH;
                            n_wait  = w_poll_load;
                        end
                    end
                end
                PH_STRETCH: begin
                    n_polls = w_polls_dec;
                    if (i_item.scl_level) begin
                        n_phase  = c_phase;
                        n_wait   = c_wait;
                        n_pulses = c_pulses;
                        n_status = c_status;
                        n_done   = c_done;
                    end else if (w_polls_dec == 8'd0) begin
                        n_phase  = PH_IDLE;
                        n_wait   = '0;
                        n_status = ST_STRETCH_TMO;
                        n_done   = 1'b1;
                    end else begin
                        n_wait = w_poll_load;
                    end
                end
                PH_START_LOW: begin
                    n_phase = PH_STOP_REL;
                    n_wait  = w_half_load;
                end
                PH_STOP_REL: begin
                    n_phase  = PH_IDLE;
                    n_wait   = '0;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            endcase
        end
    end

    // Output logic: the result reflects the state after this tick.
    always_comb begin
        o_result.scl_drive_low = (n_phase == PH_CLK_LOW);
        o_result.sda_drive_low = (n_phase == PH_START_LOW);
        o_result.pullup_on     = (n_phase != PH_IDLE);
        o_result.busy_res      = (n_phase != PH_IDLE);
        o_result.done_res      = n_done;
        o_result.status        = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_wait   <= '0;
            r_pulses <= 8'd0;
            r_polls  <= 8'd0;
            r_status <= ST_OK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_wait   <= n_wait;
            r_pulses <= n_pulses;
            r_polls  <= n_polls;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_bus_recovery.sv =====
// Top level of the tick-driven I2C bus recovery sequencer.
// The sequencer state and result register advance together; a tick's result item is registered
// and appears in the cycle after accept. One tick item per clock unless the output stalls.
// Reset (synchronous, active low): sequencer idle, counters and status zero, no result pending,
// configuration registers back to their defaults. No clearing pass is needed.
`default_nettype none

module i2c_bus_recovery
    import ibr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Tick items in.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in_item,

    // Result items out.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [DATA_WIDTH-1:0] pwdata,
    output logic      [DATA_WIDTH-1:0] prdata,
    output logic                       pready
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_accept;

    logic      r_out_valid;
    t_out_item r_out_item;

    // A new tick is taken whenever the output register is empty or is being drained in
    // the same cycle, so a waiting result never blocks the input side for more than the
    // consumer's own stall.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    ibr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The sequencer computes the next state and the result for the offered tick; both
    // are committed only when the tick is accepted.
    ibr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register. It loads on every accepted tick and otherwise holds until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/ibr_checker.sv =====
// Port-level checker for the I2C bus recovery block and its bind to the top level.
`default_nettype none

module ibr_checker
    import ibr_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input t_out_item o_out_item
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // Pullups follow the running state exactly.
    a_pullup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.pullup_on == o_out_item.busy_res))
        else $error("pullup enable differs from busy");

    // A finishing tick leaves the bus idle and released.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |->
            !o_out_item.busy_res && !o_out_item.scl_drive_low && !o_out_item.sda_drive_low)
        else $error("finish while lines still driven");

    // SCL and SDA are never pulled low together, and only while running.
    a_drive_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.scl_drive_low || o_out_item.sda_drive_low) |->
            !(o_out_item.scl_drive_low && o_out_item.sda_drive_low) && o_out_item.busy_res)
        else $error("illegal line drive combination");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind i2c_bus_recovery ibr_checker u_ibr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== bench/tb_i2c_bus_recovery.sv =====
// Self-checking testbench for the I2C bus recovery sequencer: directed and random ticks.
module tb_i2c_bus_recovery;
    import ibr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A run of this many cycles with no item moving on either channel and no register
    // write means the block has hung.
    localparam int WATCHDOG_LIMIT = 5000;

    // Directed tick scripts, three bits per tick in the order action, sda, scl, first
    // tick in the top bits.
    // Script A runs with settle 0, half 1, poll 1, poll limit 0, pulse limit 1. It covers
    // a start ignored while busy, a low SCL after a release with a zero poll limit,
    // SDA still low once the pulses are used up, SCL stuck at the first check and a
    // clean start-then-stop, each followed by released lines with pullups off.
    localparam int SCRIPT_A_LEN = 15;
    localparam logic [47:0] SCRIPT_A = {
        3'b011, 3'b101, 3'b101, 3'b001, 3'b000,
        3'b101, 3'b001, 3'b001, 3'b001, 3'b110,
        3'b010, 3'b111, 3'b011, 3'b011, 3'b011, 3'b000
    };
    // Script B runs with settle 1, half 1, poll 1, poll limit 2, pulse limit 1. One pulse,
    // then SCL is held low across a poll and released, and the sequence completes.
    localparam int SCRIPT_B_LEN = 8;
    localparam logic [47:0] SCRIPT_B = {
        3'b101, 3'b001, 3'b001, 3'b000, 3'b000, 3'b011, 3'b011, 3'b011, 24'd0
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    // Ticks waiting to be offered, and the result items predicted for accepted ticks.
    t_in_item  tick_q[$];
    t_out_item predicted_res_q[$];

    // Percent chance that the sender holds back a tick, and that the receiver stalls.
    int unsigned in_gap_pct = 0;
    int unsigned out_stall_pct = 0;

    int errors = 0;
    int quiet_cycles = 0;

    // Shadow copy of the configuration registers, starting from their reset values.
    t_cfg cfg_copy = '{settle_ticks: SETTLE_RESET, half_ticks: HALF_RESET,
                       poll_ticks: POLL_RESET, poll_limit: PLIM_RESET,
                       pulse_limit: PULSE_RESET};

    // Predicted sequencer state.
    t_phase                 seq_phase = PH_IDLE;
    logic [TIMER_WIDTH-1:0] tick_cnt = '0;
    logic [7:0]             pulses_rem = '0;
    logic [7:0]             polls_rem = '0;
    t_status                result_code = ST_OK;
    bit                     seq_done = 1'b0;

    i2c_bus_recovery dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // A phase of D ticks counts down from D-1. Zero behaves as one tick, and anything
    // beyond the timer range pins the counter at its maximum.
    function automatic logic [TIMER_WIDTH-1:0] ticks_to_count(input logic [31:0] dur);
        longint unsigned span;
        span = longint'(dur);
        if (span == 0) begin
            return '0;
        end
        if (span - 1 > (64'd1 << TIMER_WIDTH) - 1) begin
            return '1;
        end
        return TIMER_WIDTH'(span - 1);
    endfunction

    function automatic void end_sequence(input t_status code);
        seq_phase   = PH_IDLE;
        tick_cnt    = '0;
        result_code = code;
        seq_done    = 1'b1;
    endfunction

    // With SDA high the bus is free and the start-then-stop follows. With SDA low
    // another clock pulse is spent, if any are left.
    function automatic void after_sda_check(input bit sda_high);
        if (sda_high) begin
            seq_phase = PH_START_LOW;
            tick_cnt  = ticks_to_count(32'(cfg_copy.half_ticks));
        end else if (pulses_rem != 0) begin
            pulses_rem = pulses_rem - 8'd1;
            seq_phase  = PH_CLK_LOW;
            tick_cnt   = ticks_to_count(32'(cfg_copy.half_ticks));
        end else begin
            end_sequence(ST_SDA_STUCK);
        end
    endfunction

    // Advances the predicted sequencer by one tick and returns the result item it owes.
    function automatic t_out_item recovery_step(input t_in_item tick);
        t_out_item res;
        seq_done = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (tick.action) begin
                seq_phase  = PH_SETTLE;
                tick_cnt   = ticks_to_count(32'(cfg_copy.settle_ticks));
                pulses_rem = cfg_copy.pulse_limit;
                polls_rem  = '0;
            end
        end else if (tick_cnt != 0) begin
            tick_cnt = tick_cnt - TIMER_WIDTH'(1);
        end else begin
            case (seq_phase)
                PH_SETTLE: begin
                    if (!tick.scl_level) begin
                        end_sequence(ST_SCL_STUCK);
                    end else begin
                        after_sda_check(tick.sda_level);
                    end
                end
                PH_CLK_LOW: begin
                    seq_phase = PH_CLK_REL;
                    tick_cnt  = ticks_to_count(32'(cfg_copy.half_ticks));
                end
                PH_CLK_REL: begin
                    if (tick.scl_level) begin
                        after_sda_check(tick.sda_level);
                    end else begin
                        polls_rem = cfg_copy.poll_limit;
                        if (polls_rem == 0) begin
                            end_sequence(ST_STRETCH_TMO);
                        end else begin
                            seq_phase = PH_STRETCH;
                            tick_cnt  = ticks_to_count(32'(cfg_copy.poll_ticks));
                        end
                    end
                end
                PH_STRETCH: begin
                    if (polls_rem != 0) begin
                        polls_rem = polls_rem - 8'd1;
                    end
                    if (tick.scl_level) begin
                        after_sda_check(tick.sda_level);
                    end else if (polls_rem == 0) begin
                        end_sequence(ST_STRETCH_TMO);
                    end else begin
                        tick_cnt = ticks_to_count(32'(cfg_copy.poll_ticks));
                    end
                end
                PH_START_LOW: begin
                    seq_phase = PH_STOP_REL;
                    tick_cnt  = ticks_to_count(32'(cfg_copy.half_ticks));
                end
                PH_STOP_REL: begin
                    end_sequence(ST_OK);
                end
                default: begin
                    seq_phase = PH_IDLE;
                    tick_cnt  = '0;
                end
            endcase
        end
        res.scl_drive_low = (seq_phase == PH_CLK_LOW);
        res.sda_drive_low = (seq_phase == PH_START_LOW);
        res.pullup_on     = (seq_phase != PH_IDLE);
        res.busy_res      = (seq_phase != PH_IDLE);
        res.done_res      = seq_done;
        res.status        = result_code;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [1:0] want,
                                        input logic [1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Tick driver. The prediction is taken at the edge where the tick is accepted, so
    // the shadow state always matches what the block has seen. A new tick is offered
    // only once the current one is gone; otherwise valid and the item hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_res_q.push_back(recovery_step(i_in_item));
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= tick_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every accepted result item is matched against the oldest
    // prediction, one field at a time. Ready is rerolled every cycle.
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_res_q.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    errors++;
                end else begin
                    want = predicted_res_q.pop_front();
                    check_field("scl_drive_low", {1'b0, want.scl_drive_low},
                                {1'b0, o_out_item.scl_drive_low});
                    check_field("sda_drive_low", {1'b0, want.sda_drive_low},
                                {1'b0, o_out_item.sda_drive_low});
                    check_field("pullup_on", {1'b0, want.pullup_on},
                                {1'b0, o_out_item.pullup_on});
                    check_field("busy_res", {1'b0, want.busy_res},
                                {1'b0, o_out_item.busy_res});
                    check_field("done_res", {1'b0, want.done_res},
                                {1'b0, o_out_item.done_res});
                    check_field("status", want.status, o_out_item.status);
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One APB write: setup cycle, then an access cycle held until pready. The shadow
    // copy follows at the edge where the block takes the write.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SETTLE_TICKS: cfg_copy.settle_ticks = val[23:0];
            REG_HALF_TICKS:   cfg_copy.half_ticks   = val[9:0];
            REG_POLL_TICKS:   cfg_copy.poll_ticks   = val[23:0];
            REG_POLL_LIMIT:   cfg_copy.poll_limit   = val[7:0];
            REG_PULSE_LIMIT:  cfg_copy.pulse_limit  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_cfg(input int unsigned settle, input int unsigned half,
                            input int unsigned poll, input int unsigned plim,
                            input int unsigned pulse);
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_HALF_TICKS, half);
        write_reg(REG_POLL_TICKS, poll);
        write_reg(REG_POLL_LIMIT, plim);
        write_reg(REG_PULSE_LIMIT, pulse);
    endtask

    // Checked at the falling edge, when every queue and valid has settled: nothing
    // left to send, nothing in flight, every result checked.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || i_in_valid || predicted_res_q.size() != 0);
    endtask

    // Feeds plain ticks with both lines high until a running sequence has finished,
    // so that registers are only ever rewritten with the sequencer idle.
    task automatic drain_sequence();
        wait_quiet();
        while (seq_phase != PH_IDLE) begin
            repeat (8) tick_q.push_back(t_in_item'(3'b011));
            wait_quiet();
        end
    endtask

    task automatic queue_script(input logic [47:0] script, input int len);
        for (int k = 0; k < len; k++) begin
            tick_q.push_back(t_in_item'(script[47 - 3*k -: 3]));
        end
    endtask

    // Random ticks in bursts. Each burst has its own bus mood: how often SDA and SCL
    // read low. This gives both clean recoveries and every kind of failure.
    task automatic queue_random_ticks(input int count, input int unsigned start_pct);
        int          left;
        int          run;
        int unsigned sda_low_pct;
        int unsigned scl_low_pct;
        t_in_item    tick;
        left = count;
        while (left > 0) begin
            run = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       sda_low_pct = 10;
                1:       sda_low_pct = 50;
                default: sda_low_pct = 90;
            endcase
            case ($urandom_range(0, 2))
                0:       scl_low_pct = 5;
                1:       scl_low_pct = 25;
                default: scl_low_pct = 60;
            endcase
            for (int k = 0; k < run && left > 0; k++) begin
                tick.action    = ($urandom_range(0, 99) < start_pct);
                tick.sda_level = ($urandom_range(0, 99) >= sda_low_pct);
                tick.scl_level = ($urandom_range(0, 99) >= scl_low_pct);
                tick_q.push_back(tick);
                left--;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling on either side.
        load_cfg(0, 1, 1, 0, 1);
        queue_script(SCRIPT_A, SCRIPT_A_LEN);
        drain_sequence();
        load_cfg(1, 1, 1, 2, 1);
        queue_script(SCRIPT_B, SCRIPT_B_LEN);
        drain_sequence();

        // Random phases. The idling pattern rotates: none, sender gaps, receiver
        // stalls, then both at a lighter rate.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
                1: begin in_gap_pct = 65; out_stall_pct = 0;  end
                2: begin in_gap_pct = 0;  out_stall_pct = 65; end
                default: begin in_gap_pct = 22; out_stall_pct = 22; end
            endcase
            case (ph)
                2: begin
                    // Long low and release phases.
                    load_cfg(3, 64, 2, 1, 1);
                    queue_random_ticks(60, 12);
                end
                5: begin
                    // Largest pulse and poll counts with the shortest phases.
                    load_cfg(0, 1, 1, 255, 255);
                    queue_random_ticks(100, 12);
                end
                7: begin
                    // All registers at their top values. No start is requested here,
                    // since a settle this long would outlast the run; the block must
                    // simply stay idle.
                    load_cfg(24'hFFFFFF, 1023, 24'hFFFFFF, 255, 255);
                    queue_random_ticks(30, 0);
                end
                default: begin
                    load_cfg($urandom_range(0, 6), $urandom_range(1, 3), $urandom_range(1, 4),
                             $urandom_range(0, 4), $urandom_range(0, 5));
                    queue_random_ticks(90, 12);
                end
            endcase
            drain_sequence();
        end

        // Wait for any stray result item before checking that none is left.
        repeat (4) @(posedge i_clk);
        if (predicted_res_q.size() != 0) begin
            $error("%0d predicted result items never arrived", predicted_res_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ibr_pkg.sv
rtl/ibr_regs.sv
rtl/ibr_seq.sv
rtl/i2c_bus_recovery.sv
rtl/ibr_checker.sv
bench/tb_i2c_bus_recovery.sv
